// ----- design/dl2i_pkg.sv -----
// Shared types and constants for the decimal literal to int32 converter.
// No dependencies; every other design file imports this package.
package dl2i_pkg;

    localparam int ACC_W  = 36;  // accumulator width, holds 10*2^31 + 9 with sign
    localparam int ADDR_W = 4;   // three 32-bit registers at byte addresses 0, 4, 8

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [30:0]        MAX_VALUE_RST  = 31'h7FFF_FFFF;
    localparam logic signed [31:0] MIN_VALUE_RST  = 32'sh8000_0001;
    localparam logic signed [31:0] NULL_VALUE_RST = 32'sh8000_0000;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_MAX_VALUE  = 2'd0,
        REG_MIN_VALUE  = 2'd1,
        REG_NULL_VALUE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       empty_token;
    } req_t;

    typedef struct packed {
        logic signed [31:0] int_value;
        status_t            status;
        logic               is_null;
    } rsp_t;

    typedef struct packed {
        logic [30:0]        max_value;
        logic signed [31:0] min_value;
        logic signed [31:0] null_value;
    } cfg_t;

    typedef struct packed {
        logic                    at_start;
        logic                    negative;
        logic                    digit_seen;
        logic signed [ACC_W-1:0] accumulator;
        status_t                 error_code;
    } lit_state_t;

    localparam lit_state_t LIT_CLEAR = '{
        at_start:    1'b1,
        negative:    1'b0,
        digit_seen:  1'b0,
        accumulator: '0,
        error_code:  STATUS_OK
    };

endpackage

// ----- design/dl2i_regs.sv -----
// APB configuration registers: max_value, min_value, null_value.
// Depends on dl2i_pkg.
module dl2i_regs
    import dl2i_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_value  <= MAX_VALUE_RST;
            cfg_reg.min_value  <= MIN_VALUE_RST;
            cfg_reg.null_value <= NULL_VALUE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MAX_VALUE:  cfg_reg.max_value  <= pwdata[30:0];
                REG_MIN_VALUE:  cfg_reg.min_value  <= $signed(pwdata);
                REG_NULL_VALUE: cfg_reg.null_value <= $signed(pwdata);
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAX_VALUE:  prdata = {1'b0, cfg_reg.max_value};
            REG_MIN_VALUE:  prdata = cfg_reg.min_value;
            REG_NULL_VALUE: prdata = cfg_reg.null_value;
            default:        prdata = '0;
        endcase
    end

endmodule

// ----- design/dl2i_step.sv -----
// One character step of the literal parser: next literal state and result.
// Depends on dl2i_pkg.
module dl2i_step
    import dl2i_pkg::*;
(
    input  lit_state_t state,
    input  cfg_t       cfg,
    input  req_t       req,
    output lit_state_t state_next,
    output rsp_t       rsp,
    output logic       has_rsp
);

    logic                    is_digit;
    logic [3:0]              digit;
    logic signed [ACC_W-1:0] acc_x10;
    logic signed [ACC_W-1:0] acc_up;
    logic signed [ACC_W-1:0] acc_dn;
    logic signed [ACC_W-1:0] max_ext;
    logic signed [ACC_W-1:0] min_ext;

    assign is_digit = (req.char_code >= CHAR_ZERO) && (req.char_code <= CHAR_NINE);
    assign digit    = 4'(req.char_code - CHAR_ZERO);
    // x10 as shift-and-add
    assign acc_x10  = (state.accumulator <<< 3) + (state.accumulator <<< 1);
    assign acc_up   = acc_x10 + $signed({{(ACC_W-4){1'b0}}, digit});
    assign acc_dn   = acc_x10 - $signed({{(ACC_W-4){1'b0}}, digit});
    assign max_ext  = $signed({{(ACC_W-31){1'b0}}, cfg.max_value});
    assign min_ext  = $signed({{(ACC_W-32){cfg.min_value[31]}}, cfg.min_value});

    always_comb
    begin
        lit_state_t nxt;
        status_t    err_final;
        logic       sign_char;

        nxt       = state;
        err_final = STATUS_OK;
        sign_char = 1'b0;
        rsp       = '{int_value: '0, status: STATUS_OK, is_null: 1'b0};
        has_rsp   = 1'b0;

        if (req.empty_token)
        begin
            nxt     = LIT_CLEAR;
            rsp     = '{int_value: cfg.null_value, status: STATUS_OK, is_null: 1'b1};
            has_rsp = 1'b1;
        end
        else
        begin
            sign_char    = state.at_start &&
                           (req.char_code == CHAR_MINUS || req.char_code == CHAR_PLUS);
            nxt.at_start = 1'b0;
            if (state.at_start && req.char_code == CHAR_MINUS)
            begin
                nxt.negative = 1'b1;
            end

            // only the first error sticks
            if (!sign_char && state.error_code == STATUS_OK)
            begin
                if (!is_digit)
                begin
                    nxt.error_code = STATUS_INVALID;
                end
                else
                begin
                    nxt.digit_seen = 1'b1;
                    if (nxt.negative)
                    begin
                        nxt.accumulator = acc_dn;
                        if (acc_dn < min_ext)
                        begin
                            nxt.error_code = STATUS_OVERFLOW;
                        end
                    end
                    else
                    begin
                        nxt.accumulator = acc_up;
                        if (acc_up > max_ext)
                        begin
                            nxt.error_code = STATUS_OVERFLOW;
                        end
                    end
                end
            end

            if (req.last_char)
            begin
                // bare sign or nothing parsed
                err_final = (nxt.error_code == STATUS_OK && !nxt.digit_seen) ?
                            STATUS_INVALID : nxt.error_code;
                rsp.int_value = (err_final == STATUS_OK) ? nxt.accumulator[31:0] : '0;
                rsp.status    = err_final;
                rsp.is_null   = 1'b0;
                has_rsp       = 1'b1;
                nxt           = LIT_CLEAR;
            end
        end

        state_next = nxt;
    end

endmodule

// ----- design/decimal_literal_to_int32.sv -----
// Top level of the decimal literal to int32 converter.
// Depends on dl2i_pkg, dl2i_regs and dl2i_step.
//
//  channel   signals                                   moves
//  -------   ---------------------------------------   ---------------------------
//  request   req_valid / req_ready / req_data (req_t)   one character or empty mark
//  result    rsp_valid / rsp_ready / rsp_data (rsp_t)   value, status, null flag
//  config    psel penable pwrite paddr pwdata prdata    max, min, null registers
//
// One request per cycle sustained while the parse stage is not blocked. A request
// is registered in the input stage, then parsed by one shift-add x10 step plus a
// range compare, and a result (last character or empty token) lands in the result
// register. The result register only blocks the parse stage when it is full and a
// new result is due; requests that make no result always drain.
// Reset (rst_n, async low) loads the register defaults and clears all valids and
// the literal state; no clearing pass is needed.
module decimal_literal_to_int32
    import dl2i_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req_data,
    // result channel
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp_data,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t       cfg;

    // input stage
    logic       s1_valid_reg;
    req_t       s1_data_reg;

    // literal state carried between characters
    lit_state_t state_reg;
    lit_state_t state_next;

    // result stage
    logic       rsp_valid_reg;
    rsp_t       rsp_data_reg;

    rsp_t       step_rsp;
    logic       step_has_rsp;
    logic       rsp_free;
    logic       s1_go;

    dl2i_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dl2i_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .req        (s1_data_reg),
        .state_next (state_next),
        .rsp        (step_rsp),
        .has_rsp    (step_has_rsp)
    );

    // Result register can take a new result when empty or being drained.
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    // Parse stage advances unless it would produce a result with nowhere to go.
    assign s1_go     = s1_valid_reg && (!step_has_rsp || rsp_free);
    assign req_ready = !s1_valid_reg || s1_go;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= LIT_CLEAR;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                state_reg <= state_next;
            end

            if (s1_go && step_has_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_data_reg <= req_data;
        end
        if (s1_go && step_has_rsp)
        begin
            rsp_data_reg <= step_rsp;
        end
    end

endmodule

// ----- design/dl2i_checker.sv -----
// Port-level checks on the converter, attached to the top level by bind.
// Depends on dl2i_pkg and decimal_literal_to_int32.
module dl2i_checker
    import dl2i_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result dropped or changed while stalled");

    a_null_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.is_null |-> rsp_data.status == STATUS_OK)
        else $error("null result with error status");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.int_value == 32'sd0)
        else $error("error result with nonzero value");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.status == STATUS_OK || rsp_data.status == STATUS_INVALID ||
                      rsp_data.status == STATUS_OVERFLOW)
        else $error("undefined status code");

endmodule

bind decimal_literal_to_int32 dl2i_checker u_dl2i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
